// File: rtl/core/tsa_pkg.sv
// shared types and constants for the triangle strip assembler
// no dependencies; imported by every module of the block
package tsa_pkg;

  localparam int unsigned IndexW = 16;
  localparam logic [IndexW-1:0] RestartIndex = {IndexW{1'b1}};

  // countdown and list position codes
  localparam logic [1:0] GroupSize = 2'd3;
  localparam logic [1:0] CountOne  = 2'd1;
  localparam logic [1:0] CountZero = 2'd0;

  typedef enum logic {
    MODE_STRIP = 1'b0,
    MODE_LIST  = 1'b1
  } primitive_mode_e;

  // one input item
  typedef struct packed {
    logic [IndexW-1:0] vertex_index;
    logic              mesh_start;
  } vertex_item_t;

  // one result item
  typedef struct packed {
    logic [IndexW-1:0] corner_a;
    logic [IndexW-1:0] corner_b;
    logic [IndexW-1:0] corner_c;
  } triangle_t;

  // input stage to assembler
  typedef struct packed {
    logic         valid;
    vertex_item_t item;
  } in_stage_t;

  // assembler to output stage
  typedef struct packed {
    logic      load;
    logic      emit;
    triangle_t corners;
  } asm_res_t;

endpackage

// File: rtl/core/triangle_strip_assembler_top.sv
// Triangle strip assembler: takes one 16-bit vertex index per item and emits
// triangles in strip (with 0xFFFF restart) or list mode. One index is accepted
// every clock cycle while the input is not stalled; a triangle is valid on the
// output once its last index has passed the input register and the triangle
// has been loaded into the result register. The rate is set by the update of
// the three-index window and counters, which forms each triangle in the same
// cycle as it advances. Stalls on the output hold the result register and
// back up into the input register.
// depends on tsa_pkg, tsa_in_stage, tsa_assembler, tsa_out_stage
module triangle_strip_assembler_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tsa_pkg::vertex_item_t in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output tsa_pkg::triangle_t    out_tri_o
);
  import tsa_pkg::*;

  in_stage_t stage;
  asm_res_t  res;
  logic      mid_stall;

  // input register
  tsa_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .down_stall_i (mid_stall),
    .stage_o      (stage)
  );

  // state update and triangle forming
  tsa_assembler u_assembler (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .stage_i      (stage),
    .down_stall_i (mid_stall),
    .res_o        (res)
  );

  // result register
  tsa_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .up_stall_o  (mid_stall),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_tri_o   (out_tri_o)
  );

`ifndef NO_ASSERTIONS
  // input stalls only while the input register holds an item
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> stage.valid)
    else $error("input stalled with empty input register");

  // the assembler never advances into a held result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !res.load)
    else $error("result register overwritten while stalled");

  // a held result stays in place
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_tri_o)))
    else $error("stalled result changed");
`endif

endmodule

// File: rtl/core/tsa_in_stage.sv
// input register stage of the triangle strip assembler
// depends on tsa_pkg
module tsa_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tsa_pkg::vertex_item_t in_item_i,
  input  logic                  down_stall_i,
  output tsa_pkg::in_stage_t    stage_o
);
  import tsa_pkg::*;

  logic         valid_q, valid_d;
  vertex_item_t item_q, item_d;
  logic         accept;

  // stall only while holding an item that cannot move on
  assign in_stall_o = valid_q & down_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // next stage contents
  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (accept) begin
      valid_d = 1'b1;
      item_d  = in_item_i;
    end else if (valid_q && !down_stall_i) begin
      valid_d = 1'b0;
    end
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

// File: rtl/core/tsa_assembler.sv
// assembly state and triangle forming logic of the triangle strip assembler
// depends on tsa_pkg
module tsa_assembler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  tsa_pkg::in_stage_t stage_i,
  input  logic               down_stall_i,
  output tsa_pkg::asm_res_t  res_o
);
  import tsa_pkg::*;

  primitive_mode_e   mode_q;
  logic [IndexW-1:0] newest_q, newest_d;
  logic [IndexW-1:0] middle_q, middle_d;
  logic [IndexW-1:0] oldest_q, oldest_d;
  logic [1:0]        fill_q, fill_d;
  logic              odd_q, odd_d;
  logic [1:0]        lpos_q, lpos_d;

  logic              fire;
  logic [IndexW-1:0] v;
  logic [IndexW-1:0] b_newest, b_middle, b_oldest;
  logic [1:0]        b_fill, b_lpos, lpos_inc, fill_dec;
  logic              b_odd;
  logic              emit;
  triangle_t         tri_form;

  assign fire = stage_i.valid & ~down_stall_i;
  assign v    = stage_i.item.vertex_index;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_STRIP;
    end else if (cfg_we_i) begin
      mode_q <= primitive_mode_e'(cfg_wdata_i);
    end
  end

  // state as seen after an optional mesh start
  always_comb begin
    b_newest = newest_q;
    b_middle = middle_q;
    b_oldest = oldest_q;
    b_fill   = fill_q;
    b_odd    = odd_q;
    b_lpos   = lpos_q;
    if (stage_i.item.mesh_start) begin
      b_newest = '0;
      b_middle = '0;
      b_oldest = '0;
      b_fill   = GroupSize;
      b_odd    = 1'b0;
      b_lpos   = CountZero;
    end
  end

  assign lpos_inc = b_lpos + CountOne;
  assign fill_dec = (b_fill != CountZero) ? b_fill - CountOne : CountZero;

  // next state and triangle
  always_comb begin
    newest_d = b_newest;
    middle_d = b_middle;
    oldest_d = b_oldest;
    fill_d   = b_fill;
    odd_d    = b_odd;
    lpos_d   = b_lpos;
    emit     = 1'b0;
    tri_form = '{corner_a: v, corner_b: b_newest, corner_c: b_middle};
    unique case (mode_q)
      MODE_LIST: begin
        newest_d = v;
        middle_d = b_newest;
        oldest_d = b_middle;
        if (lpos_inc == GroupSize) begin
          lpos_d = CountZero;
          emit   = 1'b1;
        end else begin
          lpos_d = lpos_inc;
        end
      end
      MODE_STRIP: begin
        if (v == RestartIndex) begin
          fill_d = GroupSize;
          odd_d  = 1'b0;
        end else begin
          newest_d = v;
          middle_d = b_newest;
          oldest_d = b_middle;
          fill_d   = fill_dec;
          if (fill_dec == CountZero) begin
            // degenerate triangles still count for winding
            emit  = (v != b_newest) && (b_newest != b_middle) && (v != b_middle);
            odd_d = ~b_odd;
            fill_d = CountOne;
            if (b_odd) begin
              tri_form = '{corner_a: b_middle, corner_b: b_newest, corner_c: v};
            end
          end
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= '0;
      middle_q <= '0;
      oldest_q <= '0;
      fill_q   <= GroupSize;
      odd_q    <= 1'b0;
      lpos_q   <= CountZero;
    end else if (fire) begin
      newest_q <= newest_d;
      middle_q <= middle_d;
      oldest_q <= oldest_d;
      fill_q   <= fill_d;
      odd_q    <= odd_d;
      lpos_q   <= lpos_d;
    end
  end

  assign res_o.load    = fire;
  assign res_o.emit    = emit;
  assign res_o.corners = tri_form;

`ifndef NO_ASSERTIONS
  // countdown is reloaded to one once a strip triangle forms
  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != CountZero)
    else $error("strip countdown reached zero in state");

  // list position wraps before a full group is stored
  a_lpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lpos_q != GroupSize)
    else $error("list position holds a full group");

  // strip restart reloads the countdown and clears winding
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && mode_q == MODE_STRIP && v == RestartIndex) |=>
      (fill_q == GroupSize && !odd_q))
    else $error("restart did not reset strip state");
`endif

endmodule

// File: rtl/core/tsa_out_stage.sv
// result register stage of the triangle strip assembler
// depends on tsa_pkg
module tsa_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsa_pkg::asm_res_t  res_i,
  output logic               up_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tsa_pkg::triangle_t out_tri_o
);
  import tsa_pkg::*;

  logic      valid_q, valid_d;
  triangle_t tri_q, tri_d;

  // a waiting triangle holds the upstream stage
  assign up_stall_o = valid_q & out_stall_i;

  // next register contents
  always_comb begin
    valid_d = valid_q;
    tri_d   = tri_q;
    if (res_i.load) begin
      valid_d = res_i.emit;
      tri_d   = res_i.corners;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tri_q <= tri_d;
  end

  assign out_valid_o = valid_q;
  assign out_tri_o   = tri_q;

endmodule

// File: test/triangle_strip_assembler_checker.sv
// checker for the triangle strip assembler: tracks the mode register, predicts
// the triangles formed by accepted index items and compares accepted results
// depends on tsa_pkg
module triangle_strip_assembler_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  tsa_pkg::vertex_item_t in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  tsa_pkg::triangle_t    out_tri_i,
  output int unsigned           pending_o,
  output int unsigned           mismatch_count_o
);
  import tsa_pkg::*;

  localparam int unsigned ReportLimit = 10;

  // shadow copy of the mode register and the assembly window
  primitive_mode_e   cur_mode;
  logic [IndexW-1:0] newest;
  logic [IndexW-1:0] middle;
  logic [IndexW-1:0] oldest;
  logic [1:0]        fill_left;
  logic              odd_parity;
  logic [1:0]        group_pos;

  triangle_t   expected_tris[$];
  triangle_t   predicted;
  triangle_t   want;
  logic        emits;
  int unsigned errors;

  function automatic void clear_window();
    newest     = '0;
    middle     = '0;
    oldest     = '0;
    fill_left  = GroupSize;
    odd_parity = 1'b0;
    group_pos  = CountZero;
  endfunction

  // advance the window by one index item; returns 1 when a triangle forms
  function automatic logic assemble_vertex(input vertex_item_t it, output triangle_t shape);
    logic hit;
    hit = 1'b0;
    shape = '0;
    if (it.mesh_start) begin
      clear_window();
    end
    if (cur_mode == MODE_LIST) begin
      // plain list: every third index closes a group, reversed order
      oldest    = middle;
      middle    = newest;
      newest    = it.vertex_index;
      group_pos = group_pos + 2'd1;
      if (group_pos == GroupSize) begin
        group_pos      = CountZero;
        shape.corner_a = newest;
        shape.corner_b = middle;
        shape.corner_c = oldest;
        hit            = 1'b1;
      end
    end else if (it.vertex_index == RestartIndex) begin
      // strip restart keeps the window contents
      fill_left  = GroupSize;
      odd_parity = 1'b0;
    end else begin
      oldest = middle;
      middle = newest;
      newest = it.vertex_index;
      if (fill_left != CountZero) begin
        fill_left = fill_left - 2'd1;
      end
      if (fill_left == CountZero) begin
        // degenerate triangles are dropped but still flip the winding
        if (newest != middle && middle != oldest && newest != oldest) begin
          hit = 1'b1;
          if (odd_parity) begin
            shape.corner_a = oldest;
            shape.corner_b = middle;
            shape.corner_c = newest;
          end else begin
            shape.corner_a = newest;
            shape.corner_b = middle;
            shape.corner_c = oldest;
          end
        end
        odd_parity = ~odd_parity;
        fill_left  = CountOne;
      end
    end
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mode = MODE_STRIP;
      clear_window();
      expected_tris.delete();
      errors = 0;
      pending_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      // compare an accepted triangle with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_tris.size() == 0) begin
          errors++;
          if (errors <= ReportLimit) begin
            $display("%0t: triangle %h %h %h with none outstanding", $realtime,
                     out_tri_i.corner_a, out_tri_i.corner_b, out_tri_i.corner_c);
          end
        end else begin
          want = expected_tris.pop_front();
          if (out_tri_i.corner_a !== want.corner_a || out_tri_i.corner_b !== want.corner_b ||
              out_tri_i.corner_c !== want.corner_c) begin
            errors++;
            if (errors <= ReportLimit) begin
              $display("%0t: triangle mismatch: expected %h %h %h, got %h %h %h", $realtime,
                       want.corner_a, want.corner_b, want.corner_c,
                       out_tri_i.corner_a, out_tri_i.corner_b, out_tri_i.corner_c);
            end
          end
        end
      end
      // predict from an accepted index item
      if (in_valid_i && !in_stall_i) begin
        emits = assemble_vertex(in_item_i, predicted);
        if (emits) begin
          expected_tris.insert(expected_tris.size(), predicted);
        end
      end
      // mode write takes effect for later items
      if (cfg_we_i) begin
        cur_mode = primitive_mode_e'(cfg_wdata_i);
      end
      pending_o <= expected_tris.size();
      mismatch_count_o <= errors;
    end
  end

endmodule

// File: test/triangle_strip_assembler_top_test.sv
// testbench top for the triangle strip assembler: clock, reset, index stimulus
// with random gaps and stalls, mode writes between phases, and the verdict
// depends on tsa_pkg, triangle_strip_assembler_top, triangle_strip_assembler_checker
module triangle_strip_assembler_top_test;
  import tsa_pkg::*;

  localparam int unsigned PhaseCount  = 10;
  localparam int unsigned PhaseItems  = 165;
  localparam int unsigned SettleDelay = 4;
  localparam int unsigned RunLimit    = 2000000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic         cfg_wdata = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  vertex_item_t in_item = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  triangle_t    out_tri;
  logic         send_gaps = 1'b1;
  logic         recv_stalls = 1'b1;
  int unsigned  pending;
  int unsigned  mismatches;

  triangle_strip_assembler_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_tri_o  (out_tri)
  );

  triangle_strip_assembler_checker checker_inst (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_item_i       (in_item),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_tri_i       (out_tri),
    .pending_o       (pending),
    .mismatch_count_o(mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // triangle sink stalls at random
  always @(posedge clk) begin
    out_stall <= recv_stalls && ($urandom_range(99) < 33);
  end

  initial begin
    #(RunLimit);
    $display("== FAIL ==");
    $finish;
  end

  // offer one index item, with a random gap first, and wait for acceptance
  task automatic send_vertex(input logic [IndexW-1:0] idx, input logic start);
    while (send_gaps && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item.vertex_index <= idx;
    in_item.mesh_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every predicted triangle is back and the pipe is empty
  task automatic drain_triangles();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleDelay) @(posedge clk);
  endtask

  task automatic write_mode(input primitive_mode_e m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [IndexW-1:0] idx;
    logic              start;
    int unsigned       run_left;
    primitive_mode_e   phase_mode;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // strip: extremes, odd winding, degenerate, restart, mesh start
    write_mode(MODE_STRIP);
    send_vertex(16'h0000, 1'b0);
    send_vertex(16'h0001, 1'b0);
    send_vertex(16'h0002, 1'b0);
    send_vertex(16'hFFFE, 1'b0);
    send_vertex(16'h0002, 1'b0);
    send_vertex(16'h8000, 1'b0);
    send_vertex(RestartIndex, 1'b0);
    send_vertex(RestartIndex, 1'b0);
    send_vertex(16'h5555, 1'b0);
    send_vertex(16'hAAAA, 1'b0);
    send_vertex(16'h7FFF, 1'b0);
    send_vertex(16'h1234, 1'b1);
    send_vertex(16'h4321, 1'b0);
    send_vertex(16'h0003, 1'b1);
    send_vertex(RestartIndex, 1'b1);
    drain_triangles();

    // list: restart code as plain index, partial group dropped
    write_mode(MODE_LIST);
    send_vertex(RestartIndex, 1'b0);
    send_vertex(RestartIndex, 1'b0);
    send_vertex(RestartIndex, 1'b0);
    send_vertex(16'h0000, 1'b0);
    send_vertex(RestartIndex, 1'b0);
    send_vertex(16'h8001, 1'b0);
    send_vertex(16'h0004, 1'b0);
    send_vertex(16'h0005, 1'b1);
    send_vertex(16'h0006, 1'b0);
    send_vertex(16'h0007, 1'b0);
    drain_triangles();

    // random phases; meshes carry over across mode changes unless restarted
    run_left = 0;
    for (int p = 0; p < PhaseCount; p++) begin
      if (p < 4) begin
        phase_mode = primitive_mode_e'(p % 2);
      end else begin
        phase_mode = primitive_mode_e'($urandom_range(1));
      end
      write_mode(phase_mode);
      send_gaps <= (p != 5);
      recv_stalls <= (p != 5);
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(99) < 10) begin
          // noise item
          idx = IndexW'($urandom);
          start = 1'($urandom_range(1));
        end else begin
          start = 1'b0;
          if (run_left == 0) begin
            run_left = $urandom_range(24, 1);
            start = ($urandom_range(99) < 85);
          end
          run_left--;
          if (phase_mode == MODE_STRIP && $urandom_range(99) < 8) begin
            idx = RestartIndex;
          end else begin
            case ($urandom_range(3))
              0: idx = IndexW'($urandom_range(5));
              1, 2: idx = IndexW'($urandom);
              default: begin
                if ($urandom_range(1) != 0) begin
                  idx = RestartIndex - IndexW'($urandom_range(2));
                end else begin
                  idx = IndexW'($urandom_range(2));
                end
              end
            endcase
          end
        end
        send_vertex(idx, start);
      end
      drain_triangles();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/tsa_pkg.sv
rtl/core/tsa_in_stage.sv
rtl/core/tsa_assembler.sv
rtl/core/tsa_out_stage.sv
rtl/core/triangle_strip_assembler_top.sv
test/triangle_strip_assembler_checker.sv
test/triangle_strip_assembler_top_test.sv
